### rtl/core/sha512_pkg.sv
`default_nettype none
package sha512_pkg;
  localparam int Rounds = 80;
  localparam int WordW = 64;
  localparam int CntW = 4;
  localparam int CfgIdxW = 3;
  localparam logic [63:0] PadWord = 64'h8000000000000000;
  localparam logic [63:0] IvReset [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  typedef struct packed {
    logic [63:0] word;
    logic        first;
    logic        fin;
  } blk_word_t;

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] k;
    unique case (t)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction
endpackage
`default_nettype wire

### rtl/core/sha512_front.sv
`default_nettype none
module sha512_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [63:0]           msg_word,
  input  wire logic [3:0]            valid_bytes,
  input  wire logic                  msg_last,
  output logic                       q_push,
  output sha512_pkg::blk_word_t      q_data,
  input  wire logic                  q_full
);
  import sha512_pkg::*;

  typedef enum logic [1:0] {S_MSG, S_PAD, S_LEN} state_t;
  state_t state;
  logic [3:0] word_index;
  logic [63:0] bit_length;
  logic in_message;
  logic pad_first;
  logic [3:0] n;
  logic [63:0] mask, padded, len_next;

  always_comb begin
    n = (!msg_last || valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
    mask = (n == 4'd0) ? 64'd0 : ~(64'd0) << (7'd64 - {n, 3'b000});
    padded = (msg_word & mask) | (64'h80 << (7'd56 - {n, 3'b000}));
    len_next = bit_length + {57'd0, n, 3'b000};
  end

  assign in_ready = (state == S_MSG) && !q_full;
  assign q_push = !q_full && ((state != S_MSG) || in_valid);

  // pad stage emits the 0x80 word first when the last word was full
  always_comb begin
    q_data.first = 1'b0;
    q_data.fin = 1'b0;
    q_data.word = '0;
    unique case (state)
      S_MSG: begin
        q_data.first = !in_message;
        q_data.word = (msg_last && n != 4'd8) ? padded : msg_word;
      end
      S_PAD: q_data.word = pad_first ? PadWord : 64'd0;
      S_LEN: begin
        q_data.word = bit_length;
        q_data.fin = 1'b1;
      end
      default: q_data.word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_MSG;
      word_index <= '0;
      bit_length <= '0;
      in_message <= 1'b0;
      pad_first <= 1'b0;
    end else if (q_push) begin
      word_index <= word_index + 4'd1;
      unique case (state)
        S_MSG: begin
          in_message <= 1'b1;
          bit_length <= len_next;
          if (msg_last) begin
            pad_first <= (n == 4'd8);
            state <= S_PAD;
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          if (word_index == 4'd14 && !pad_first) state <= S_LEN;
        end
        S_LEN: begin
          state <= S_MSG;
          word_index <= '0;
          bit_length <= '0;
          in_message <= 1'b0;
        end
        default: state <= S_MSG;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/sha512_queue.sv
`default_nettype none
module sha512_queue #(
  parameter int W = 66
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  logic [W-1:0] mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  assign full = cnt == 3'd4;
  assign empty = cnt == 3'd0;
  assign rdata = mem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) wp <= wp + 2'd1;
      if (pop && !empty) rp <= rp + 2'd1;
      cnt <= cnt + {2'd0, push && !full} - {2'd0, pop && !empty};
    end
  end
  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= wdata;
  end
endmodule
`default_nettype wire

### rtl/core/sha512_back.sv
`default_nettype none
module sha512_back #(
  parameter int ROUNDS = sha512_pkg::Rounds
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  input  sha512_pkg::blk_word_t      q_data,
  output logic                       q_pop,
  input  wire logic [63:0]           iv [8],
  output logic                       empty,
  input  wire logic                  pop,
  output logic [63:0]                digest_word,
  output logic                       digest_last
);
  import sha512_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_RND, S_ADD, S_OUT} state_t;
  state_t state;
  logic [63:0] h [8];
  logic [63:0] v [8];
  logic [63:0] w [16];
  logic [3:0] widx;
  logic [6:0] t;
  logic fin;
  logic [2:0] oidx;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int s);
    return (x >> s) | (x << (64 - s));
  endfunction

  logic [63:0] wt, s0, s1, t1, t2, e1, a0, ch, mj;
  always_comb begin
    s1 = rotr(w[14], 19) ^ rotr(w[14], 61) ^ (w[14] >> 6);
    s0 = rotr(w[1], 1) ^ rotr(w[1], 8) ^ (w[1] >> 7);
    wt = (t < 7'd16) ? w[0] : s1 + w[9] + s0 + w[0];
    e1 = rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    a0 = rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + e1 + ch + round_k(t) + wt;
    t2 = a0 + mj;
  end

  assign q_pop = (state == S_LOAD) && !q_empty;
  assign empty = state != S_OUT;
  assign digest_word = h[oidx];
  assign digest_last = oidx == 3'd7;

  // window shifts each round; w[0] is the round word for t < 16, later words come from w[0], w[1], w[9], w[14]
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      widx <= '0;
      t <= '0;
      fin <= 1'b0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) h[i] <= IvReset[i];
    end else begin
      unique case (state)
        S_LOAD: if (!q_empty) begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= q_data.word;
          if (q_data.first) for (int i = 0; i < 8; i++) h[i] <= iv[i];
          if (q_data.fin) fin <= 1'b1;
          widx <= widx + 4'd1;
          if (widx == 4'd15) begin
            state <= S_RND;
            t <= '0;
            for (int i = 0; i < 8; i++) v[i] <= q_data.first ? iv[i] : h[i];
          end
        end
        S_RND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wt;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          t <= t + 7'd1;
          if (t == 7'(ROUNDS - 1)) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          state <= fin ? S_OUT : S_LOAD;
          fin <= 1'b0;
          oidx <= '0;
        end
        S_OUT: if (pop) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/sha512_hash_engine_top.sv
`default_nettype none
// channel  handshake                direction  payload
// input    push / full              in         msg_word, valid_bytes, msg_last
// result   empty / pop              out        digest_word, digest_last
// config   cfg_valid / cfg_ready    in         cfg_index, cfg_data
// the front pads and feeds a four-entry queue; the back loads 16 words then runs
// 80 serial rounds and an add step per block; each message ends in eight digest transfers
// rst is synchronous; it restores the standard initial values
// full rises when the queue fills while the back is in its rounds, its add step or holds a digest
// full also stays high while the front emits the padding and length words
module sha512_hash_engine_top #(
  parameter int ROUNDS = sha512_pkg::Rounds
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [63:0] msg_word,
  input  wire logic [3:0]  valid_bytes,
  input  wire logic        msg_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      digest_word,
  output logic             digest_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import sha512_pkg::*;

  logic [63:0] iv [8];
  logic in_ready, q_push, q_full, q_empty, q_pop;
  blk_word_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;
  assign full = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) iv[i] <= IvReset[i];
    end else if (cfg_valid && cfg_index[3] == 1'b0) begin
      iv[cfg_index[2:0]] <= cfg_data;
    end
  end

  sha512_front u_front (
    .clk, .rst, .in_valid(push), .in_ready, .msg_word, .valid_bytes, .msg_last,
    .q_push, .q_data(q_wdata), .q_full
  );

  sha512_queue #(.W($bits(blk_word_t))) u_queue (
    .clk, .rst, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  sha512_back #(.ROUNDS(ROUNDS)) u_back (
    .clk, .rst, .q_empty, .q_data(q_rdata), .q_pop, .iv,
    .empty, .pop, .digest_word, .digest_last
  );
endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

class digest_scoreboard;
  logic [63:0] iv_regs [8];
  logic [63:0] hash_words [8];
  logic [63:0] block_buf [16];
  int unsigned word_idx;
  logic [63:0] bit_len;
  bit in_msg;
  logic [63:0] exp_word [$];
  bit exp_last [$];
  int errors;
  int digests;

  function new();
    for (int i = 0; i < 8; i++) begin
      iv_regs[i] = sha512_pkg::IvReset[i];
      hash_words[i] = sha512_pkg::IvReset[i];
    end
    word_idx = 0;
    bit_len = '0;
    in_msg = 0;
    errors = 0;
    digests = 0;
  endfunction

  function void write_iv(logic [3:0] idx, logic [63:0] data);
    if (idx < 8) iv_regs[idx[2:0]] = data;
  endfunction

  static function logic [63:0] rotr(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  static function logic [63:0] rk(int t);
    logic [63:0] k [80];
    k = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    return k[t];
  endfunction

  function void compress();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2, s0, s1;
    for (int i = 0; i < 8; i++) v[i] = hash_words[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        w[t] = block_buf[t];
      end else begin
        s1 = rotr(w[t-2], 19) ^ rotr(w[t-2], 61) ^ (w[t-2] >> 6);
        s0 = rotr(w[t-15], 1) ^ rotr(w[t-15], 8) ^ (w[t-15] >> 7);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rk(t) + w[t];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] += v[i];
  endfunction

  function void load_word(logic [63:0] w);
    block_buf[word_idx] = w;
    word_idx = (word_idx + 1) % 16;
    if (word_idx == 0) compress();
  endfunction

  function void note_word(logic [63:0] word, logic [3:0] nbytes, logic last);
    int n;
    logic [63:0] mask;
    if (!in_msg) begin
      for (int i = 0; i < 8; i++) hash_words[i] = iv_regs[i];
      in_msg = 1;
    end
    n = (nbytes > 8 || !last) ? 8 : nbytes;
    bit_len += 64'(8 * n);
    if (!last) begin
      load_word(word);
      return;
    end
    if (n == 8) begin
      load_word(word);
      load_word(sha512_pkg::PadWord);
    end else begin
      mask = (n == 0) ? '0 : ~64'h0 << (64 - 8 * n);
      load_word((word & mask) | (64'h80 << (56 - 8 * n)));
    end
    while (word_idx != 14) load_word('0);
    load_word('0);
    load_word(bit_len);
    for (int i = 0; i < 8; i++) begin
      exp_word = {exp_word, hash_words[i]};
      exp_last = {exp_last, bit'(i == 7)};
    end
    word_idx = 0;
    bit_len = '0;
    in_msg = 0;
  endfunction

  function void check_digest(logic [63:0] dw, logic dl);
    logic [63:0] ew;
    logic el;
    if (exp_word.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected digest transfer %h last %b", dw, dl);
      return;
    end
    ew = exp_word.pop_front();
    el = exp_last.pop_front();
    if (el) digests++;
    if (dw !== ew || dl !== el) begin
      errors++;
      if (errors <= 10)
        $display("digest mismatch: expected %h/%b got %h/%b", ew, el, dw, dl);
    end
  endfunction
endclass

module testbench;
  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic [63:0] msg_word = '0;
  logic [3:0] valid_bytes = '0;
  logic msg_last = 0;
  logic empty;
  logic pop = 0;
  logic [63:0] digest_word;
  logic digest_last;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  digest_scoreboard sb = new();
  int cycles = 0;
  int hold_off = 0;
  bit stall_req = 0;
  bit pop_idle = 0;
  int words_sent = 0;
  int cfg_writes = 0;
  localparam int Limit = 400000;

  sha512_hash_engine_top dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("timeout");
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side with random stalls
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_digest(digest_word, digest_last);
    if (stall_req) begin
      stall_req <= 0;
      hold_off <= 800;
      pop <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 0;
    end else if (pop_idle) begin
      pop <= 1;
    end else begin
      case ($urandom_range(0, 9))
        0: pop <= 0;
        1: begin
          pop <= 0;
          hold_off <= $urandom_range(5, 40);
        end
        default: pop <= 1;
      endcase
    end
  end

  task automatic gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) push <= 0;
    repeat (g) @(posedge clk);
  endtask

  task automatic send_word(logic [63:0] w, logic [3:0] n, logic l);
    push <= 1;
    msg_word <= w;
    valid_bytes <= n;
    msg_last <= l;
    do @(posedge clk); while (full);
    sb.note_word(w, n, l);
    words_sent++;
  endtask

  task automatic send_paced(logic [63:0] w, logic [3:0] n, logic l);
    gap();
    send_word(w, n, l);
  endtask

  task automatic drain();
    push <= 0;
    while (sb.exp_word.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_iv(idx, data);
    cfg_writes++;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_msg(int len);
    for (int i = 0; i < len - 1; i++)
      send_paced(rand64(), 4'($urandom_range(0, 15)), 0);
    send_paced(rand64(), ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                      : 4'($urandom_range(0, 8)), 1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty message, byte counts, edge values
    send_word('0, 4'd0, 1);
    send_word(64'h6162630000000000, 4'd3, 1);
    send_word('1, 4'd8, 1);
    send_word('1, 4'd7, 1);
    send_word('1, 4'd15, 1);
    send_word('1, 4'd2, 0);
    send_word(64'h0123456789abcdef, 4'd1, 1);
    for (int i = 0; i < 15; i++) send_word(64'(i) * 64'h1111, 4'd8, 0);
    send_word(64'hfedcba9876543210, 4'd8, 1);
    drain();

    // minimum and maximum initial values
    for (int i = 0; i < 8; i++) write_reg(4'(i), '0);
    write_reg(4'd9, rand64());
    send_word('0, 4'd0, 1);
    send_word('1, 4'd8, 1);
    drain();
    for (int i = 0; i < 8; i++) write_reg(4'(i), '1);
    send_word(64'h8000000000000001, 4'd4, 1);
    drain();

    // long receiver stall while the sender keeps pushing
    stall_req = 1;
    random_msg(30);
    random_msg(2);
    drain();

    for (int i = 0; i < 8; i++) write_reg(4'(i), sha512_pkg::IvReset[i]);
    while (words_sent < 115) begin
      if ($urandom_range(0, 7) == 0) begin
        drain();
        write_reg(4'($urandom_range(0, 15)), rand64());
      end
      random_msg(($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6));
    end
    drain();
    for (int i = 0; i < 8; i++) write_reg(4'(i), rand64());
    random_msg(3);
    pop_idle = 1;
    drain();

    $display("sent %0d words, checked %0d digests, %0d register writes",
             words_sent, sb.digests, cfg_writes);
    if (sb.errors == 0 && sb.exp_word.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

### files.f
rtl/core/sha512_pkg.sv
rtl/core/sha512_front.sv
rtl/core/sha512_queue.sv
rtl/core/sha512_back.sv
rtl/core/sha512_hash_engine_top.sv
test/testbench.sv
